[hw/rtl/stack_machine_execute_macros.svh]
// Assertion macros for the stack machine execution unit.
// Used by the top level only; no other dependencies.
`ifndef STACK_MACHINE_EXECUTE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/sme_pkg.sv]
// Package for the stack machine execution unit: sizes, opcodes, codes, state and divider types.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;
	localparam int STACK_DEPTH = 256;
	localparam int TAPE_DEPTH = 65536;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int TAW = $clog2(TAPE_DEPTH);
	localparam int DW = 32;
	localparam logic [TAW-1:0] TP_RESET = TAW'(TAPE_DEPTH / 2);

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_COPY = 5'd1, OP_EMITN = 5'd2, OP_EMITC = 5'd3,
		OP_LEFT = 5'd4, OP_RIGHT = 5'd5, OP_STORE = 5'd6, OP_POP = 5'd7,
		OP_LOAD = 5'd8, OP_AND = 5'd9, OP_OR = 5'd10, OP_XOR = 5'd11,
		OP_NOT = 5'd12, OP_ADD = 5'd13, OP_SUB = 5'd14, OP_MUL = 5'd15,
		OP_DIV = 5'd16, OP_MOD = 5'd17, OP_EQ = 5'd18, OP_NEQ = 5'd19,
		OP_GT = 5'd20, OP_LT = 5'd21, OP_GE = 5'd22, OP_LE = 5'd23
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;
	localparam logic [1:0] EK_NONE = 2'd0;
	localparam logic [1:0] EK_NUM = 2'd1;
	localparam logic [1:0] EK_CHAR = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_MUL, S_OUT
	} state_t;

	// Request to and answer from the divider.
	typedef struct packed {
		logic start;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
	} div_req_t;
	typedef struct packed {
		logic done;
		logic [DW-1:0] quot;
		logic [DW-1:0] rem;
	} div_rsp_t;
endpackage

[hw/rtl/sme_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface sme_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/sme_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[hw/rtl/sme_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_div (
	input logic clk,
	input logic arst_n,
	input sme_pkg::div_req_t req,
	output sme_pkg::div_rsp_t rsp
);
	localparam int CW = $clog2(sme_pkg::DW + 1);
	logic [sme_pkg::DW-1:0] q_q, d_q, r_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, neg_q_q, neg_r_q, done_q;
	logic [sme_pkg::DW:0] trial;

	assign trial = {r_q, q_q[sme_pkg::DW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(sme_pkg::DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.a[sme_pkg::DW-1] ? -req.a : req.a;
			d_q <= req.b[sme_pkg::DW-1] ? -req.b : req.b;
			r_q <= '0;
			neg_q_q <= req.a[sme_pkg::DW-1] ^ req.b[sme_pkg::DW-1];
			neg_r_q <= req.a[sme_pkg::DW-1];
		end else if (busy_q) begin
			if (!trial[sme_pkg::DW]) begin
				r_q <= trial[sme_pkg::DW-1:0];
				q_q <= {q_q[sme_pkg::DW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[sme_pkg::DW-2:0], q_q[sme_pkg::DW-1]};
				q_q <= {q_q[sme_pkg::DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q_q ? -q_q : q_q;
	assign rsp.rem = neg_r_q ? -r_q : r_q;
endmodule

[hw/rtl/stack_machine_execute.sv]
// Top level of the stack machine execution unit: sequencer, stack and tape memories.
// Depends on sme_pkg, sme_if, sme_ram, sme_div and the assertion macros header.
`timescale 1ns / 1ps
`include "stack_machine_execute_macros.svh"
//
// Channel  Direction  Payload
// in       sink       func[4:0], immediate[31:0]
// out      source     top_value[31:0], emit_kind[1:0], status[1:0], stack_depth[8:0]
//
// Each item goes through accept, a read of the second stack entry (the top is cached)
// and the tape cell from their one-port memories, compute and write back, then present
// the result. Multiply adds the S_MUL state for its registered product; divide and
// modulo by a nonzero divisor wait in S_DIV for the bit-serial divider. After reset a
// clearing pass zeroes the tape, one entry a cycle, and no item is accepted until it
// ends. A stalled result holds the unit; the next item can be taken in the cycle after it leaves.
module stack_machine_execute (
	input logic clk,
	input logic arst_n,
	sme_if.sink in,
	sme_if.source out
);
	localparam int SAW = sme_pkg::SAW;
	localparam int SCW = sme_pkg::SCW;
	localparam int TAW = sme_pkg::TAW;
	localparam int DW = sme_pkg::DW;

	sme_pkg::state_t state_q, state_d;
	logic [SCW-1:0] cnt_q;
	logic [TAW-1:0] tp_q, clr_q;
	logic [4:0] op_q;
	logic [DW-1:0] imm_q;
	logic [DW-1:0] top_q;
	logic [DW-1:0] top_out;
	logic [1:0] kind_q, status_q;
	logic [DW-1:0] prod_q;

	// Stack memory: the top entry is cached in top_q, the memory holds the rest
	// below it, so one read port gives the second entry.
	logic s_we;
	logic [SAW-1:0] s_addr;
	logic [DW-1:0] s_wdata, s_rdata;
	logic t_we;
	logic [TAW-1:0] t_addr;
	logic [DW-1:0] t_wdata, t_rdata;

	sme_ram #(.WIDTH(DW), .DEPTH(sme_pkg::STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
	);
	sme_ram #(.WIDTH(DW), .DEPTH(sme_pkg::TAPE_DEPTH)) u_tape (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
	);

	sme_pkg::div_req_t dreq;
	sme_pkg::div_rsp_t drsp;
	sme_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Operand classification.
	logic need1, need2, push_op, under, over;
	always_comb begin
		need1 = 1'b0;
		need2 = 1'b0;
		push_op = 1'b0;
		case (op_q) inside
			sme_pkg::OP_PUSH, sme_pkg::OP_LOAD: push_op = 1'b1;
			sme_pkg::OP_COPY: begin
				push_op = 1'b1;
				need1 = 1'b1;
			end
			sme_pkg::OP_EMITN, sme_pkg::OP_EMITC, sme_pkg::OP_STORE, sme_pkg::OP_POP,
			sme_pkg::OP_NOT: need1 = 1'b1;
			[sme_pkg::OP_AND:sme_pkg::OP_LE]: need2 = 1'b1;
			default: ;
		endcase
		under = (need2 && cnt_q < SCW'(2)) || (need1 && cnt_q == '0);
		over = push_op && cnt_q == SCW'(sme_pkg::STACK_DEPTH);
	end

	// ALU on a = second entry (memory), b = top (cached).
	logic [DW-1:0] a, b, alu;
	assign a = s_rdata;
	assign b = top_q;
	always_comb begin
		case (op_q)
			sme_pkg::OP_AND: alu = a & b;
			sme_pkg::OP_OR: alu = a | b;
			sme_pkg::OP_XOR: alu = a ^ b;
			sme_pkg::OP_ADD: alu = a + b;
			sme_pkg::OP_SUB: alu = a - b;
			sme_pkg::OP_EQ: alu = DW'(a == b);
			sme_pkg::OP_NEQ: alu = DW'(a != b);
			sme_pkg::OP_GT: alu = DW'($signed(a) > $signed(b));
			sme_pkg::OP_LT: alu = DW'($signed(a) < $signed(b));
			sme_pkg::OP_GE: alu = DW'($signed(a) >= $signed(b));
			sme_pkg::OP_LE: alu = DW'($signed(a) <= $signed(b));
			default: alu = '0;
		endcase
	end

	logic acc;
	assign acc = in.valid && in.ready;

	// The new top after a binary op replaces the second entry; the memory entry at
	// cnt-2 then becomes stale but sits under the cached top, which is never reread.
	logic set_top, dec1, inc1;
	logic [DW-1:0] new_top;
	always_comb begin
		state_d = state_q;
		in.ready = 1'b0;
		out.valid = 1'b0;
		s_we = 1'b0;
		s_addr = SAW'(cnt_q - SCW'(2));
		s_wdata = top_q;
		t_we = 1'b0;
		t_addr = tp_q;
		t_wdata = top_q;
		dreq.start = 1'b0;
		dreq.a = a;
		dreq.b = b;
		set_top = 1'b0;
		dec1 = 1'b0;
		inc1 = 1'b0;
		new_top = alu;
		unique case (state_q)
			sme_pkg::S_CLEAR: begin
				t_we = 1'b1;
				t_addr = clr_q;
				t_wdata = '0;
				if (clr_q == TAW'(sme_pkg::TAPE_DEPTH - 1)) state_d = sme_pkg::S_IDLE;
			end
			sme_pkg::S_IDLE: begin
				in.ready = 1'b1;
				if (in.valid) state_d = sme_pkg::S_READ;
			end
			sme_pkg::S_READ: state_d = sme_pkg::S_EXEC;
			sme_pkg::S_EXEC: begin
				state_d = sme_pkg::S_OUT;
				if (!under && !over) begin
					case (op_q)
						sme_pkg::OP_PUSH, sme_pkg::OP_COPY, sme_pkg::OP_LOAD: begin
							// Spill the cached top below the new one.
							s_we = cnt_q != '0;
							s_addr = SAW'(cnt_q - SCW'(1));
							set_top = 1'b1;
							inc1 = 1'b1;
							new_top = op_q == sme_pkg::OP_PUSH ? imm_q :
								op_q == sme_pkg::OP_LOAD ? t_rdata : top_q;
						end
						sme_pkg::OP_STORE: t_we = 1'b1;
						sme_pkg::OP_POP: begin
							set_top = 1'b1;
							dec1 = 1'b1;
							new_top = s_rdata;
						end
						sme_pkg::OP_NOT: begin
							set_top = 1'b1;
							new_top = DW'(top_q == '0);
						end
						sme_pkg::OP_MUL: state_d = sme_pkg::S_MUL;
						sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
							if (b != '0) begin
								dreq.start = 1'b1;
								state_d = sme_pkg::S_DIV;
							end
						end
						default: begin
							if (need2) begin
								set_top = 1'b1;
								dec1 = 1'b1;
							end
						end
					endcase
				end
			end
			sme_pkg::S_MUL: begin
				set_top = 1'b1;
				dec1 = 1'b1;
				new_top = prod_q;
				state_d = sme_pkg::S_OUT;
			end
			sme_pkg::S_DIV: begin
				if (drsp.done) begin
					set_top = 1'b1;
					dec1 = 1'b1;
					new_top = op_q == sme_pkg::OP_DIV ? drsp.quot : drsp.rem;
					state_d = sme_pkg::S_OUT;
				end
			end
			sme_pkg::S_OUT: begin
				out.valid = 1'b1;
				if (out.ready) state_d = sme_pkg::S_IDLE;
			end
			default: state_d = sme_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::S_CLEAR;
			cnt_q <= '0;
			tp_q <= sme_pkg::TP_RESET;
			clr_q <= '0;
			status_q <= sme_pkg::ST_OK;
			kind_q <= sme_pkg::EK_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == sme_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (inc1) cnt_q <= cnt_q + 1'b1;
			else if (dec1) cnt_q <= cnt_q - 1'b1;
			if (state_q == sme_pkg::S_EXEC) begin
				kind_q <= sme_pkg::EK_NONE;
				if (under) status_q <= sme_pkg::ST_UNDER;
				else if (over) status_q <= sme_pkg::ST_OVER;
				else if ((op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD) && b == '0)
					status_q <= sme_pkg::ST_DIVZ;
				else status_q <= sme_pkg::ST_OK;
				if (!under && !over) begin
					if (op_q == sme_pkg::OP_EMITN) kind_q <= sme_pkg::EK_NUM;
					if (op_q == sme_pkg::OP_EMITC) kind_q <= sme_pkg::EK_CHAR;
					if (op_q == sme_pkg::OP_LEFT) tp_q <= tp_q - 1'b1;
					if (op_q == sme_pkg::OP_RIGHT) tp_q <= tp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q <= in.data[DW+4:DW];
			imm_q <= in.data[DW-1:0];
		end
		if (set_top) top_q <= new_top;
		prod_q <= a * b;
	end

	// The reported top reads as zero when the stack is empty.
	always_comb top_out = cnt_q == '0 ? '0 : top_q;
	assign out.data = {top_out, kind_q, status_q, cnt_q};

	`SME_ASSERT_IMP(a_no_acc_busy, clk, arst_n, state_q != sme_pkg::S_IDLE, !in.ready,
		"item accepted while busy")
	`SME_ASSERT_IMP(a_depth_range, clk, arst_n, 1'b1, cnt_q <= SCW'(sme_pkg::STACK_DEPTH),
		"stack depth beyond capacity")
	`SME_ASSERT_NEXT(a_fault_hold, clk, arst_n,
		state_q == sme_pkg::S_EXEC && (under || over), $stable(cnt_q),
		"stack changed on fault")
endmodule
